// ----- sv/cclm_pkg.sv -----
`default_nettype none
package cclm_pkg;

    // command codes of an input word
    localparam logic [2:0] CMD_MIDI      = 3'd0;
    localparam logic [2:0] CMD_LEARN     = 3'd1;
    localparam logic [2:0] CMD_CLEAR     = 3'd2;
    localparam logic [2:0] CMD_BIND      = 3'd3;
    localparam logic [2:0] CMD_SET_LOW   = 3'd4;
    localparam logic [2:0] CMD_SET_HIGH  = 3'd5;

    // event codes of a result word
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_PRESS      = 3'd1;
    localparam logic [2:0] EV_RELEASE    = 3'd2;
    localparam logic [2:0] EV_CONTINUOUS = 3'd3;
    localparam logic [2:0] EV_LEARNED    = 3'd4;
    localparam logic [2:0] EV_NOT_CC     = 3'd5;

    localparam int CC_COUNT = 128;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] midi_status;
        logic [6:0] controller_number;
        logic [6:0] controller_value;
        logic [5:0] action_id;
        logic       action_is_button;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [5:0] target_action;
        logic [6:0] scaled_value;
        logic [6:0] event_controller;
    } evt_word_t;

    typedef struct packed {
        logic [5:0] action;
        logic       button;
        logic [6:0] low;
        logic [6:0] high;
        logic [6:0] last_value;
        logic       autorange;
    } entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic ld_in;
        logic scan_en;
        logic rd_issue;
        logic rmw;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic need_scan;
        logic need_rmw;
        logic scan_done;
        logic div_req;
        logic div_busy;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/cclm_cmd_if.sv -----
`default_nettype none
interface cclm_cmd_if;
    logic                 valid;
    logic                 ready;
    cclm_pkg::cmd_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/cclm_evt_if.sv -----
`default_nettype none
interface cclm_evt_if;
    logic                 valid;
    logic                 ready;
    cclm_pkg::evt_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/midi_cc_learn_mapper.sv -----
// A controller message passes through decode, table read, write-back, the 14-step restoring
// divider when a continuous value is scaled, and the result load.
// Learn, clear, bind and limit words with an in-range action, and a message that completes a
// learn, scan all 128 table entries through the single read port, one a cycle.
// One word is in work at a time; the next word is taken once its result is loaded.
// Reset clears all bindings, limits, last values, autorange flags and the learn state.
`default_nettype none
module midi_cc_learn_mapper #(
    parameter int ACTION_COUNT = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cclm_cmd_if.sink      cmd_ch,
    cclm_evt_if.source    evt_ch
);
    import cclm_pkg::*;

    ctrl_cmd_t ctl_cmd;
    dp_stat_t  dp_stat;

    cclm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_ch.valid),
        .in_ready (cmd_ch.ready),
        .stat     (dp_stat),
        .cmd      (ctl_cmd)
    );

    cclm_dp #(
        .ACTION_COUNT (ACTION_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctl_cmd),
        .stat      (dp_stat),
        .in_word   (cmd_ch.data),
        .out_valid (evt_ch.valid),
        .out_ready (evt_ch.ready),
        .out_word  (evt_ch.data)
    );

endmodule
`default_nettype wire

// ----- sv/cclm_ctrl.sv -----
`default_nettype none
module cclm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire cclm_pkg::dp_stat_t   stat,
    output cclm_pkg::ctrl_cmd_t       cmd
);
    import cclm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_RMW  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // sequence one word through scan, read-modify-write and divide
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.ld_in  = in_valid;
                if (in_valid)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.need_scan)
                begin
                    state_next = S_SCAN;
                end
                else if (stat.need_rmw)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = !stat.scan_done;
                if (stat.scan_done)
                begin
                    state_next = stat.need_rmw ? S_RD : S_DONE;
                end
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RMW;
            end
            S_RMW:
            begin
                cmd.rmw    = 1'b1;
                state_next = stat.div_req ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                cmd.div_step = stat.div_busy;
                if (!stat.div_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.out_load = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_rd_then_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |=> cmd.rmw)
        else $error("read not followed by write-back");
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> stat.div_busy)
        else $error("divide step with no divide running");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (state_reg == S_IDLE && !cmd.scan_en))
        else $error("result load did not return to idle");
    a_rmw_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rmw && stat.div_req) |=> stat.div_busy)
        else $error("divide requested but not started");

endmodule
`default_nettype wire

// ----- sv/cclm_dp.sv -----
`default_nettype none
module cclm_dp #(
    parameter int ACTION_COUNT = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cclm_pkg::ctrl_cmd_t  cmd,
    output cclm_pkg::dp_stat_t        stat,
    input  wire cclm_pkg::cmd_word_t  in_word,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output cclm_pkg::evt_word_t       out_word
);
    import cclm_pkg::*;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_NOTCC  = 3'd1;
    localparam logic [2:0] OP_UNBIND = 3'd2;
    localparam logic [2:0] OP_BIND   = 3'd3;
    localparam logic [2:0] OP_LIMIT  = 3'd4;
    localparam logic [2:0] OP_MSG    = 3'd5;

    localparam logic [3:0] DIV_STEPS = 4'd14;

    // latched word and learn state
    logic [2:0] op_reg;
    logic [2:0] op_next;
    logic [5:0] key_reg;
    logic [5:0] key_next;
    logic       btn_reg;
    logic       btn_next;
    logic       learned_reg;
    logic       learned_next;
    logic [6:0] cc_reg;
    logic [6:0] val_reg;
    logic       set_high_reg;
    logic       learn_pending_reg;
    logic [5:0] learn_target_reg;
    logic       learn_button_reg;

    // table
    entry_t           mem [CC_COUNT];
    logic [CC_COUNT-1:0] bound_reg;
    logic [CC_COUNT-1:0] wvalid_reg;
    entry_t           rd_data_reg;
    logic             rd_ok_reg;
    entry_t           e;

    // scan
    logic [7:0] scan_cnt_reg;
    logic       chk_v_reg;
    logic [6:0] chk_idx_reg;
    logic       found_reg;
    logic [6:0] found_idx_reg;
    logic       match;
    logic       scan_rd;

    // divider
    logic [3:0]  div_cnt_reg;
    logic [7:0]  div_rem_reg;
    logic [13:0] div_q_reg;
    logic [6:0]  div_den_reg;
    logic        div_neg_reg;
    logic [7:0]  div_trial;

    // result
    logic [2:0] res_ev_reg;
    logic [5:0] res_act_reg;
    logic [6:0] res_cc_reg;
    logic       res_div_reg;
    logic       out_valid_reg;
    evt_word_t  out_word_reg;

    logic [6:0] rd_addr;
    logic       act_ok;
    logic       is_cc;

    // decode the incoming word
    always_comb
    begin
        act_ok       = ({3'b000, in_word.action_id} < 9'(ACTION_COUNT));
        is_cc        = (in_word.midi_status[7:4] == 4'hB);
        op_next      = OP_NONE;
        key_next     = in_word.action_id;
        btn_next     = in_word.action_is_button;
        learned_next = 1'b0;
        unique case (in_word.cmd) inside
            CMD_MIDI:
            begin
                if (!is_cc)
                begin
                    op_next = OP_NOTCC;
                end
                else if (learn_pending_reg)
                begin
                    op_next      = OP_BIND;
                    key_next     = learn_target_reg;
                    btn_next     = learn_button_reg;
                    learned_next = 1'b1;
                end
                else
                begin
                    op_next = OP_MSG;
                end
            end
            CMD_LEARN, CMD_CLEAR:
            begin
                op_next = act_ok ? OP_UNBIND : OP_NONE;
            end
            CMD_BIND:
            begin
                op_next = act_ok ? OP_BIND : OP_NONE;
            end
            CMD_SET_LOW, CMD_SET_HIGH:
            begin
                op_next = act_ok ? OP_LIMIT : OP_NONE;
            end
            default:
            begin
                op_next = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg            <= OP_NONE;
            learn_pending_reg <= 1'b0;
            learn_target_reg  <= '0;
            learn_button_reg  <= 1'b0;
        end
        else if (cmd.ld_in)
        begin
            op_reg <= op_next;
            if (in_word.cmd == CMD_LEARN && act_ok)
            begin
                learn_pending_reg <= 1'b1;
                learn_target_reg  <= in_word.action_id;
                learn_button_reg  <= in_word.action_is_button;
            end
            else if (learned_next)
            begin
                learn_pending_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            key_reg      <= key_next;
            btn_reg      <= btn_next;
            learned_reg  <= learned_next;
            cc_reg       <= in_word.controller_number;
            val_reg      <= in_word.controller_value;
            set_high_reg <= (in_word.cmd == CMD_SET_HIGH);
        end
    end

    // issue scan reads only for the 128 table entries
    assign scan_rd = cmd.scan_en && !scan_cnt_reg[7];

    // table read port
    always_comb
    begin
        if (scan_rd)
        begin
            rd_addr = scan_cnt_reg[6:0];
        end
        else if (op_reg == OP_LIMIT)
        begin
            rd_addr = found_idx_reg;
        end
        else
        begin
            rd_addr = cc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_rd || cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_ok_reg   <= wvalid_reg[rd_addr];
        end
    end

    assign e = rd_ok_reg ? rd_data_reg : '0;

    // scan the table for entries bound to the key action
    assign match = chk_v_reg && bound_reg[chk_idx_reg] && (e.action == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg  <= '0;
            chk_v_reg     <= 1'b0;
            chk_idx_reg   <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
        end
        else if (cmd.ld_in)
        begin
            scan_cnt_reg <= '0;
            chk_v_reg    <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            chk_v_reg   <= scan_rd;
            chk_idx_reg <= scan_cnt_reg[6:0];
            if (scan_rd)
            begin
                scan_cnt_reg <= scan_cnt_reg + 8'd1;
            end
            if (match && !found_reg)
            begin
                found_reg     <= 1'b1;
                found_idx_reg <= chk_idx_reg;
            end
        end
    end

    // write-back computation
    logic signed [9:0] v;
    logic signed [9:0] lo;
    logic signed [9:0] hi;
    logic signed [9:0] old;
    logic signed [9:0] r;
    logic signed [9:0] ar;
    logic signed [9:0] half;
    logic signed [9:0] dd;
    logic signed [9:0] base;
    logic signed [9:0] lt;
    logic signed [9:0] ht;
    logic              pos;
    logic              outr;
    logic              inc;
    logic              dec;
    logic signed [9:0] nh;
    logic signed [9:0] nl;
    logic signed [9:0] rng;
    logic signed [9:0] num;
    logic [6:0]        num_mag;
    logic [6:0]        den_mag;
    logic              is_bound;
    entry_t            we;
    logic              wr_go;
    logic [2:0]        ev_w;
    logic              div_go;

    always_comb
    begin
        v    = $signed({3'b000, val_reg});
        lo   = $signed({3'b000, e.low});
        hi   = $signed({3'b000, e.high});
        old  = $signed({3'b000, e.last_value});
        // button hysteresis around the midpoint
        r    = hi - lo;
        pos  = (r > 10'sd0);
        ar   = pos ? r : -r;
        half = (ar + 10'sd1) >>> 1;
        dd   = (ar >= 10'sd4) ? 10'sd2 : 10'sd0;
        base = pos ? lo : hi;
        lt   = base + half - dd;
        ht   = base + half + dd;
        if (pos)
        begin
            outr = (v < lt) || (v >= ht);
            inc  = (old < lt) && (v >= ht);
            dec  = (old >= ht) && (v < lt);
        end
        else
        begin
            outr = (v >= lt) || (v < ht);
            inc  = (old >= lt) && (v < ht);
            dec  = (old < ht) && (v >= lt);
        end
        // continuous autorange and scaling operands
        nh      = (v > hi && e.autorange) ? v : hi;
        nl      = (v < lo && e.autorange) ? v : lo;
        rng     = nh - nl;
        num     = v - nl;
        num_mag = num[9] ? 7'(-num) : num[6:0];
        den_mag = rng[9] ? 7'(-rng) : rng[6:0];
        is_bound = bound_reg[cc_reg];

        we     = e;
        wr_go  = 1'b0;
        ev_w   = EV_NONE;
        div_go = 1'b0;
        case (op_reg)
            OP_BIND:
            begin
                wr_go     = 1'b1;
                we.action = key_reg;
                we.button = btn_reg;
                if (btn_reg)
                begin
                    we.low  = 7'd0;
                    we.high = 7'd127;
                end
                else
                begin
                    we.autorange = 1'b1;
                    we.low       = 7'd127;
                    we.high      = 7'd0;
                end
                if (learned_reg)
                begin
                    we.last_value = val_reg;
                    ev_w          = EV_LEARNED;
                end
            end
            OP_LIMIT:
            begin
                wr_go        = 1'b1;
                we.autorange = 1'b0;
                if (set_high_reg)
                begin
                    we.high = val_reg;
                end
                else
                begin
                    we.low = val_reg;
                end
            end
            OP_MSG:
            begin
                if (is_bound && e.button)
                begin
                    wr_go = outr;
                    we.last_value = val_reg;
                    if (inc)
                    begin
                        ev_w = EV_PRESS;
                    end
                    else if (dec)
                    begin
                        ev_w = EV_RELEASE;
                    end
                end
                else if (is_bound)
                begin
                    wr_go         = 1'b1;
                    we.high       = nh[6:0];
                    we.low        = nl[6:0];
                    we.last_value = val_reg;
                    div_go        = (rng != 10'sd0);
                    ev_w          = div_go ? EV_CONTINUOUS : EV_NONE;
                end
            end
            default:
            begin
                wr_go = 1'b0;
            end
        endcase
    end

    // table write port
    always_ff @(posedge clk)
    begin
        if (cmd.rmw && wr_go)
        begin
            mem[rd_addr] <= we;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg  <= '0;
            wvalid_reg <= '0;
        end
        else
        begin
            if (cmd.rmw && wr_go)
            begin
                wvalid_reg[rd_addr] <= 1'b1;
                if (op_reg == OP_BIND)
                begin
                    bound_reg[rd_addr] <= 1'b1;
                end
            end
            // drop every match on unbind, only the first on rebind
            if (match && (op_reg == OP_UNBIND || (op_reg == OP_BIND && !found_reg)))
            begin
                bound_reg[chk_idx_reg] <= 1'b0;
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    assign div_trial = {div_rem_reg[6:0], div_q_reg[13]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.rmw && div_go)
        begin
            div_cnt_reg <= DIV_STEPS;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rmw && div_go)
        begin
            div_q_reg   <= {num_mag, 7'b0} - {7'b0, num_mag};
            div_rem_reg <= '0;
            div_den_reg <= den_mag;
            div_neg_reg <= (num[9] != rng[9]);
        end
        else if (cmd.div_step)
        begin
            if (div_trial >= {1'b0, div_den_reg})
            begin
                div_rem_reg <= div_trial - {1'b0, div_den_reg};
                div_q_reg   <= {div_q_reg[12:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_trial;
                div_q_reg   <= {div_q_reg[12:0], 1'b0};
            end
        end
    end

    // result fields
    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            res_ev_reg  <= (op_next == OP_NOTCC) ? EV_NOT_CC : EV_NONE;
            res_act_reg <= '0;
            res_cc_reg  <= '0;
            res_div_reg <= 1'b0;
        end
        else if (cmd.rmw)
        begin
            res_ev_reg  <= ev_w;
            res_div_reg <= div_go;
            if (ev_w != EV_NONE)
            begin
                res_act_reg <= (op_reg == OP_BIND) ? key_reg : e.action;
                res_cc_reg  <= cc_reg;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_word_reg.event_res        <= res_ev_reg;
            out_word_reg.target_action    <= res_act_reg;
            out_word_reg.event_controller <= res_cc_reg;
            if (!res_div_reg || div_neg_reg)
            begin
                out_word_reg.scaled_value <= 7'd0;
            end
            else if (|div_q_reg[13:7])
            begin
                out_word_reg.scaled_value <= 7'd127;
            end
            else
            begin
                out_word_reg.scaled_value <= div_q_reg[6:0];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign stat.need_scan = (op_reg == OP_UNBIND) || (op_reg == OP_BIND)
                            || (op_reg == OP_LIMIT);
    assign stat.need_rmw  = (op_reg == OP_BIND) || (op_reg == OP_MSG)
                            || (op_reg == OP_LIMIT && found_reg);
    assign stat.scan_done = scan_cnt_reg[7] && !chk_v_reg;
    assign stat.div_req   = div_go;
    assign stat.div_busy  = (div_cnt_reg != 4'd0);
    assign stat.out_free  = !out_valid_reg || out_ready;

    a_scan_reset: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_in |=> (scan_cnt_reg == 8'd0 && !found_reg))
        else $error("scan state not cleared on new word");
    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (match && !found_reg && op_reg == OP_LIMIT) |=> found_reg)
        else $error("limit target not recorded");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("pending result dropped");

endmodule
`default_nettype wire

// ----- test/midi_cc_learn_mapper_tb.sv -----
`timescale 1ns / 1ps
module midi_cc_learn_mapper_tb;
    import cclm_pkg::*;

    localparam int N_ACT = 64;
    localparam int WATCHDOG_CYCLES = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cclm_cmd_if cmd_ch ();
    cclm_evt_if evt_ch ();

    midi_cc_learn_mapper #(.ACTION_COUNT(N_ACT)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch.sink),
        .evt_ch (evt_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the controller table
    logic       tbl_bound [CC_COUNT];
    logic [5:0] tbl_action [CC_COUNT];
    logic       tbl_button [CC_COUNT];
    logic [6:0] tbl_low [CC_COUNT];
    logic [6:0] tbl_high [CC_COUNT];
    logic [6:0] tbl_last [CC_COUNT];
    logic       tbl_auto [CC_COUNT];
    logic       lrn_pending;
    logic [5:0] lrn_target;
    logic       lrn_button;

    evt_word_t expected_events [$];
    int errors = 0;
    int idle_cycles = 0;
    bit stall_long = 1'b0;
    bit stim_done = 1'b0;

    function automatic int lowest_cc(input logic [5:0] act);
        for (int c = 0; c < CC_COUNT; c++)
            if (tbl_bound[c] && tbl_action[c] == act)
                return c;
        return CC_COUNT;
    endfunction

    function automatic void unbind_action(input logic [5:0] act);
        for (int c = 0; c < CC_COUNT; c++)
            if (tbl_bound[c] && tbl_action[c] == act)
                tbl_bound[c] = 1'b0;
    endfunction

    function automatic void bind_cc(input logic [5:0] act, input logic [6:0] cc,
                                    input logic btn);
        int prev;
        prev = lowest_cc(act);
        if (prev < CC_COUNT)
            tbl_bound[prev] = 1'b0;
        tbl_bound[cc] = 1'b1;
        tbl_action[cc] = act;
        tbl_button[cc] = btn;
        if (btn)
        begin
            tbl_low[cc] = 7'd0;
            tbl_high[cc] = 7'd127;
        end
        else
        begin
            tbl_auto[cc] = 1'b1;
            tbl_low[cc] = 7'd127;
            tbl_high[cc] = 7'd0;
        end
    endfunction

    function automatic void reset_table();
        for (int c = 0; c < CC_COUNT; c++)
        begin
            tbl_bound[c] = 1'b0;
            tbl_action[c] = '0;
            tbl_button[c] = 1'b0;
            tbl_low[c] = '0;
            tbl_high[c] = '0;
            tbl_last[c] = '0;
            tbl_auto[c] = 1'b0;
        end
        lrn_pending = 1'b0;
        lrn_target = '0;
        lrn_button = 1'b0;
    endfunction

    // compute the event a command word yields and update the shadow table
    function automatic evt_word_t map_event(input cmd_word_t w);
        evt_word_t e;
        int cc, v, lo, hi, rng, old, lt, ht, q, c;
        bit outr, inc, dec;
        e = '0;
        cc = int'(w.controller_number);
        v = int'(w.controller_value);
        if (w.cmd == CMD_MIDI)
        begin
            if (w.midi_status[7:4] != 4'hB)
            begin
                e.event_res = EV_NOT_CC;
                return e;
            end
            if (lrn_pending)
            begin
                bind_cc(lrn_target, cc[6:0], lrn_button);
                lrn_pending = 1'b0;
                tbl_last[cc] = v[6:0];
                e.event_res = EV_LEARNED;
                e.target_action = lrn_target;
                e.event_controller = cc[6:0];
                return e;
            end
            if (!tbl_bound[cc])
                return e;
            lo = int'(tbl_low[cc]);
            hi = int'(tbl_high[cc]);
            rng = hi - lo;
            if (tbl_button[cc])
            begin
                old = int'(tbl_last[cc]);
                if (rng > 0)
                begin
                    lt = lo + (1 + rng) / 2 - ((rng >= 4) ? 2 : 0);
                    ht = lo + (1 + rng) / 2 + ((rng >= 4) ? 2 : 0);
                    outr = v < lt || v >= ht;
                    inc = old < lt && v >= ht;
                    dec = old >= ht && v < lt;
                end
                else
                begin
                    rng = -rng;
                    lt = hi + (1 + rng) / 2 - ((rng >= 4) ? 2 : 0);
                    ht = hi + (1 + rng) / 2 + ((rng >= 4) ? 2 : 0);
                    outr = v >= lt || v < ht;
                    inc = old >= lt && v < ht;
                    dec = old < ht && v >= lt;
                end
                if (outr)
                    tbl_last[cc] = v[6:0];
                if (inc || dec)
                begin
                    e.event_res = inc ? EV_PRESS : EV_RELEASE;
                    e.target_action = tbl_action[cc];
                    e.event_controller = cc[6:0];
                end
            end
            else
            begin
                if (v > hi && tbl_auto[cc])
                begin
                    tbl_high[cc] = v[6:0];
                    hi = v;
                end
                if (v < lo && tbl_auto[cc])
                begin
                    tbl_low[cc] = v[6:0];
                    lo = v;
                end
                tbl_last[cc] = v[6:0];
                rng = hi - lo;
                if (rng != 0)
                begin
                    q = (v - lo) * 127 / rng;
                    if (q < 0) q = 0;
                    if (q > 127) q = 127;
                    e.event_res = EV_CONTINUOUS;
                    e.target_action = tbl_action[cc];
                    e.scaled_value = q[6:0];
                    e.event_controller = cc[6:0];
                end
            end
            return e;
        end
        if (w.cmd > CMD_SET_HIGH || w.action_id >= N_ACT)
            return e;
        case (w.cmd)
            CMD_LEARN:
            begin
                unbind_action(w.action_id);
                lrn_pending = 1'b1;
                lrn_target = w.action_id;
                lrn_button = w.action_is_button;
            end
            CMD_CLEAR: unbind_action(w.action_id);
            CMD_BIND: bind_cc(w.action_id, w.controller_number, w.action_is_button);
            default:
            begin
                c = lowest_cc(w.action_id);
                if (c < CC_COUNT)
                begin
                    if (w.cmd == CMD_SET_LOW)
                        tbl_low[c] = w.controller_value;
                    else
                        tbl_high[c] = w.controller_value;
                    tbl_auto[c] = 1'b0;
                end
            end
        endcase
        return e;
    endfunction

    function automatic cmd_word_t make_word(input logic [2:0] cmd, input logic [7:0] st,
                                            input logic [6:0] cc, input logic [6:0] val,
                                            input logic [5:0] act, input logic btn);
        cmd_word_t w;
        w.cmd = cmd;
        w.midi_status = st;
        w.controller_number = cc;
        w.controller_value = val;
        w.action_id = act;
        w.action_is_button = btn;
        return w;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // directed table: word plus optional typed-in expectation
    typedef struct {
        cmd_word_t word;
        bit        has_exp;
        evt_word_t exp;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic void add_row(input cmd_word_t w, input bit he, input evt_word_t ex);
        dir_row_t r;
        r.word = w;
        r.has_exp = he;
        r.exp = ex;
        dir_rows.push_back(r);
    endfunction

    function automatic evt_word_t ev(input logic [2:0] code, input logic [5:0] act,
                                     input logic [6:0] val, input logic [6:0] cc);
        evt_word_t e;
        e.event_res = code;
        e.target_action = act;
        e.scaled_value = val;
        e.event_controller = cc;
        return e;
    endfunction

    function automatic void build_directed();
        // unbound controller, non-controller status, unused codes, bind of the highest action
        add_row(make_word(CMD_MIDI, 8'hB0, 7'd0, 7'd0, 6'd0, 1'b0), 1'b1,
                ev(EV_NONE, 6'd0, 7'd0, 7'd0));
        add_row(make_word(CMD_MIDI, 8'hFF, 7'd127, 7'd127, 6'd63, 1'b1), 1'b1,
                ev(EV_NOT_CC, 6'd0, 7'd0, 7'd0));
        add_row(make_word(3'd6, 8'hB0, 7'd1, 7'd1, 6'd1, 1'b0), 1'b1,
                ev(EV_NONE, 6'd0, 7'd0, 7'd0));
        add_row(make_word(3'd7, 8'hB0, 7'd1, 7'd1, 6'd1, 1'b0), 1'b1,
                ev(EV_NONE, 6'd0, 7'd0, 7'd0));
        add_row(make_word(CMD_BIND, 8'h00, 7'd5, 7'd0, 6'd63, 1'b0), 1'b1,
                ev(EV_NONE, 6'd0, 7'd0, 7'd0));
        // learn a continuous action on the top controller
        add_row(make_word(CMD_LEARN, 8'h00, 7'd0, 7'd0, 6'd10, 1'b0), 1'b1,
                ev(EV_NONE, 6'd0, 7'd0, 7'd0));
        add_row(make_word(CMD_MIDI, 8'hBF, 7'd127, 7'd64, 6'd0, 1'b0), 1'b1,
                ev(EV_LEARNED, 6'd10, 7'd0, 7'd127));
        add_row(make_word(CMD_MIDI, 8'hB3, 7'd127, 7'd0, 6'd0, 1'b0), 1'b0, '0);
        add_row(make_word(CMD_MIDI, 8'hB3, 7'd127, 7'd127, 6'd0, 1'b0), 1'b0, '0);
        add_row(make_word(CMD_MIDI, 8'hB3, 7'd127, 7'd50, 6'd0, 1'b0), 1'b0, '0);
        // zero and inverted range through the limit commands
        add_row(make_word(CMD_SET_LOW, 8'h00, 7'd0, 7'd40, 6'd10, 1'b0), 1'b0, '0);
        add_row(make_word(CMD_SET_HIGH, 8'h00, 7'd0, 7'd40, 6'd10, 1'b0), 1'b0, '0);
        add_row(make_word(CMD_MIDI, 8'hB0, 7'd127, 7'd90, 6'd0, 1'b0), 1'b0, '0);
        add_row(make_word(CMD_SET_HIGH, 8'h00, 7'd0, 7'd10, 6'd10, 1'b0), 1'b0, '0);
        add_row(make_word(CMD_MIDI, 8'hB0, 7'd127, 7'd0, 6'd0, 1'b0), 1'b0, '0);
        add_row(make_word(CMD_MIDI, 8'hB0, 7'd127, 7'd127, 6'd0, 1'b0), 1'b0, '0);
        // button binding: press, release, hysteresis
        add_row(make_word(CMD_BIND, 8'h00, 7'd0, 7'd0, 6'd0, 1'b1), 1'b1,
                ev(EV_NONE, 6'd0, 7'd0, 7'd0));
        add_row(make_word(CMD_MIDI, 8'hB0, 7'd0, 7'd127, 6'd0, 1'b0), 1'b0, '0);
        add_row(make_word(CMD_MIDI, 8'hB0, 7'd0, 7'd62, 6'd0, 1'b0), 1'b0, '0);
        add_row(make_word(CMD_MIDI, 8'hB0, 7'd0, 7'd0, 6'd0, 1'b0), 1'b0, '0);
        add_row(make_word(CMD_SET_LOW, 8'h00, 7'd0, 7'd100, 6'd0, 1'b0), 1'b0, '0);
        add_row(make_word(CMD_MIDI, 8'hB0, 7'd0, 7'd127, 6'd0, 1'b0), 1'b0, '0);
        add_row(make_word(CMD_MIDI, 8'hB0, 7'd0, 7'd0, 6'd0, 1'b0), 1'b0, '0);
        // clear and rebind away
        add_row(make_word(CMD_CLEAR, 8'h00, 7'd0, 7'd0, 6'd0, 1'b0), 1'b1,
                ev(EV_NONE, 6'd0, 7'd0, 7'd0));
        add_row(make_word(CMD_BIND, 8'h00, 7'd3, 7'd0, 6'd10, 1'b1), 1'b1,
                ev(EV_NONE, 6'd0, 7'd0, 7'd0));
    endfunction

    // random word: mostly well-formed traffic on a small pool of controllers and actions
    function automatic cmd_word_t rand_word();
        cmd_word_t w;
        int r;
        w = '0;
        w.midi_status = {4'hB, 4'($urandom)};
        w.controller_number = ($urandom_range(0, 9) < 8) ? 7'($urandom_range(0, 7))
                                                           : 7'($urandom);
        w.controller_value = 7'($urandom);
        w.action_id = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 5)) : 6'($urandom);
        w.action_is_button = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 60) w.cmd = CMD_MIDI;
        else if (r < 66) w.cmd = CMD_LEARN;
        else if (r < 70) w.cmd = CMD_CLEAR;
        else if (r < 82) w.cmd = CMD_BIND;
        else if (r < 88) w.cmd = CMD_SET_LOW;
        else if (r < 94) w.cmd = CMD_SET_HIGH;
        else if (r < 96) w.cmd = 3'($urandom_range(6, 7));
        else
        begin
            w.cmd = CMD_MIDI;
            w.midi_status = 8'($urandom);
        end
        return w;
    endfunction

    // send one word and record its expectation
    task automatic send_word(input cmd_word_t w, input bit he, input evt_word_t ex);
        evt_word_t p;
        int g;
        g = gap_len();
        repeat (g) @(negedge clk);
        cmd_ch.valid = 1'b1;
        cmd_ch.data = w;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        p = map_event(w);
        if (he && p !== ex)
        begin
            $display("%0t: table row disagrees: expected %h predicted %h", $time, ex, p);
            errors++;
        end
        expected_events.push_back(p);
        @(negedge clk);
        cmd_ch.valid = 1'b0;
    endtask

    // sender
    initial
    begin
        cmd_word_t w;
        reset_table();
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        build_directed();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].has_exp, dir_rows[i].exp);
        for (int n = 0; n < 450; n++)
        begin
            if (n == 100)
                stall_long = 1'b1;
            if (n == 250)
            begin
                // drain every result before going on
                while (expected_events.size() != 0) @(negedge clk);
            end
            w = rand_word();
            send_word(w, 1'b0, '0);
        end
        while (expected_events.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        stim_done = 1'b1;
    end

    // receiver ready with random stalls, one long hold-off on request
    initial
    begin
        int g;
        evt_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_long)
            begin
                evt_ch.ready <= 1'b0;
                stall_long = 1'b0;
                repeat (600) @(negedge clk);
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g > 0)
            begin
                evt_ch.ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
            else
                evt_ch.ready <= 1'b1;
        end
    end

    // check results and watch for hangs
    always @(posedge clk)
    begin
        evt_word_t exp_e;
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (evt_ch.valid && evt_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (evt_ch.valid && evt_ch.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, evt_ch.data);
                    errors++;
                end
                else
                begin
                    exp_e = expected_events.pop_front();
                    if (evt_ch.data.event_res !== exp_e.event_res)
                    begin
                        $display("%0t: event_res expected %0d actual %0d", $time,
                                 exp_e.event_res, evt_ch.data.event_res);
                        errors++;
                    end
                    if (evt_ch.data.target_action !== exp_e.target_action)
                    begin
                        $display("%0t: target_action expected %0d actual %0d", $time,
                                 exp_e.target_action, evt_ch.data.target_action);
                        errors++;
                    end
                    if (evt_ch.data.scaled_value !== exp_e.scaled_value)
                    begin
                        $display("%0t: scaled_value expected %0d actual %0d", $time,
                                 exp_e.scaled_value, evt_ch.data.scaled_value);
                        errors++;
                    end
                    if (evt_ch.data.event_controller !== exp_e.event_controller)
                    begin
                        $display("%0t: event_controller expected %0d actual %0d", $time,
                                 exp_e.event_controller, evt_ch.data.event_controller);
                        errors++;
                    end
                end
            end
        end
    end

    // end of run
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stim_done)
            begin
                if (errors == 0 && expected_events.size() == 0)
                    $display("No mismatches found");
                else
                    $display("Mismatches found");
                $finish;
            end
            else if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
